[rtl/smau_pkg.sv]
// Package for the small matrix arithmetic unit: request and operation codes,
// the queue entry type, the sequencer states and the saturation helper.
// No dependencies; every other file of the block but smau_ram imports it.
`default_nettype none

package smau_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W  = 32;
    localparam int DIM_W   = 4;
    localparam int IDX_W   = 3;
    // Accumulator width: eight 64-bit products plus sign headroom.
    localparam int WIDE_W  = 67;
    localparam int QUEUE_DEPTH = 2;

    // Request codes.
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_COMP   = 2'd2;

    // Operation codes.
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_MUL   = 3'd2;
    localparam logic [2:0] OP_SCALE = 3'd3;
    localparam logic [2:0] OP_INV   = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_NUM_ROWS  = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_NUM_COLS  = 2'd2;

    typedef enum logic [1:0] {
        K_LOAD_A,
        K_LOAD_B,
        K_COMP
    } t_kind;

    // One classified item waiting for the execution side.
    typedef struct packed {
        t_kind                     kind;
        logic [2:0]                op;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [DATA_W-1:0]  value;
    } t_qent;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_ACC,
        ST_EMIT,
        ST_IREAD,
        ST_ICAP,
        ST_DET0,
        ST_DET1,
        ST_DET2,
        ST_IINIT,
        ST_DIV,
        ST_IEMIT
    } t_state;

    // Saturate a wide value to 32 bits; the top bit of the result is the
    // overflow flag.
    function automatic logic [DATA_W:0] f_sat32(input logic signed [WIDE_W-1:0] v);
        if (v > $signed({{(WIDE_W-DATA_W){1'b0}}, 32'h7FFF_FFFF})) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < $signed({{(WIDE_W-DATA_W){1'b1}}, 32'h8000_0000})) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b0, v[DATA_W-1:0]};
        end
    endfunction

endpackage

`default_nettype wire

[rtl/smau_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module smau_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/smau_front.sv]
// Front end of the matrix unit: accepts items, drops those that do nothing,
// and queues the rest for the execution side. Depends on smau_pkg.
`default_nettype none

module smau_front import smau_pkg::*; #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_req_type,
    input  wire logic [IDX_W-1:0]         i_elem_row,
    input  wire logic [IDX_W-1:0]         i_elem_col,
    input  wire logic signed [DATA_W-1:0] i_elem_value,
    input  wire logic [2:0]               i_op_code,
    input  wire logic signed [DATA_W-1:0] i_scale_factor,
    output logic                          o_q_valid,
    output t_qent                         o_q_ent,
    input  wire logic                     i_q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_qent             r_ent [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_keep;
    logic              w_push;
    logic              w_pop;
    t_qent             w_ent;

    // Classify the item: in-range loads and known computes are kept.
    always_comb begin
        w_keep = 1'b0;
        w_ent.kind  = K_COMP;
        w_ent.op    = i_op_code;
        w_ent.row   = i_elem_row;
        w_ent.col   = i_elem_col;
        w_ent.value = i_elem_value;
        priority if (i_req_type == REQ_LOAD_A || i_req_type == REQ_LOAD_B) begin
            w_ent.kind = (i_req_type == REQ_LOAD_A) ? K_LOAD_A : K_LOAD_B;
            w_keep = (32'(i_elem_row) < MAX_DIM) && (32'(i_elem_col) < MAX_DIM);
        end else if (i_req_type == REQ_COMP) begin
            w_ent.value = i_scale_factor;
            w_keep = (i_op_code <= OP_INV);
        end else begin
            w_keep = 1'b0;
        end
    end

    assign o_in_ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready && w_keep;
    assign o_q_valid  = (r_cnt != '0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_ent    = r_ent[r_rptr];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= PTR_W'((32'(r_wptr) + 1) % QUEUE_DEPTH);
            end
            if (w_pop) begin
                r_rptr <= PTR_W'((32'(r_rptr) + 1) % QUEUE_DEPTH);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!w_push && w_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wptr] <= w_ent;
        end
    end

endmodule

`default_nettype wire

[rtl/smau_back.sv]
// Execution side of the matrix unit: writes the stores, sequences the
// element operations and the 2x2 inverse, and holds the result register.
// Depends on smau_pkg and smau_ram.
`default_nettype none

module smau_back import smau_pkg::*; #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire t_qent                    i_q_ent,
    output logic                          o_q_pop,
    input  wire logic [DIM_W-1:0]         i_num_rows,
    input  wire logic [DIM_W-1:0]         i_inner_dim,
    input  wire logic [DIM_W-1:0]         i_num_cols,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [IDX_W-1:0]              o_out_row,
    output logic [IDX_W-1:0]              o_out_col,
    output logic signed [DATA_W-1:0]      o_out_value,
    output logic                          o_last_elem,
    output logic                          o_overflow_flag,
    output logic                          o_singular_flag
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CAP   = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int DIV_W = DATA_W + 2 * FRAC_BITS;
    localparam int DC_W  = $clog2(DIV_W + 1);

    function automatic logic [DIM_W-1:0] f_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (32'(v) > CAP) begin
            return DIM_W'(CAP);
        end else begin
            return v;
        end
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [IDX_W-1:0] row,
                                             input logic [IDX_W-1:0] col);
        return AW'(32'(row) * MAX_DIM + 32'(col));
    endfunction

    t_state                    r_state, n_state;
    logic [2:0]                r_op;
    logic signed [DATA_W-1:0]  r_scale;
    logic [IDX_W-1:0]          r_i, r_j, r_k;
    logic [DIM_W-1:0]          r_nr, r_nc, r_nk;
    logic signed [WIDE_W-1:0]  r_acc;
    logic signed [63:0]        r_prod;
    logic signed [WIDE_W-1:0]  r_wide;
    logic signed [DATA_W-1:0]  r_m [4];
    logic signed [64:0]        r_det;
    logic [63:0]               r_dmag;
    logic [DIV_W-1:0]          r_dvd;
    logic [63:0]               r_rem;
    logic [32:0]               r_q;
    logic                      r_big;
    logic                      r_neg;
    logic [DC_W-1:0]           r_cnt;
    logic [DEPTH-1:0]          r_a_vld, r_b_vld;
    logic                      r_a_rv, r_b_rv;
    logic                      r_ovld;

    logic                      w_we_a, w_we_b;
    logic [AW-1:0]             w_waddr;
    logic [AW-1:0]             w_ra_a, w_ra_b;
    logic [DATA_W-1:0]         w_rd_a, w_rd_b;
    logic signed [DATA_W-1:0]  w_a, w_b;
    logic                      w_oslot;
    logic                      w_load_out;
    logic signed [WIDE_W-1:0]  w_sum;
    logic [DATA_W:0]           w_sat;
    logic                      w_last;
    logic signed [32:0]        w_num;
    logic [31:0]               w_nmag;
    logic [64:0]               w_rr;
    logic                      w_ge;
    logic [33:0]               w_imag;
    logic                      w_iovf;
    logic [DATA_W-1:0]         w_ival;
    logic                      w_sing;

    // Element stores.
    smau_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_q_ent.value),
        .i_raddr (w_ra_a),
        .o_rdata (w_rd_a)
    );

    smau_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_q_ent.value),
        .i_raddr (w_ra_b),
        .o_rdata (w_rd_b)
    );

    // An entry never written since reset reads as zero.
    assign w_a     = r_a_rv ? $signed(w_rd_a) : '0;
    assign w_b     = r_b_rv ? $signed(w_rd_b) : '0;
    assign w_oslot = !r_ovld || i_out_ready;
    assign w_waddr = f_addr(i_q_ent.row, i_q_ent.col);

    // Read addresses for the element steps and the inverse corner.
    always_comb begin
        w_ra_a = '0;
        w_ra_b = '0;
        if (r_state == ST_READ) begin
            w_ra_a = f_addr(r_i, (r_op == OP_MUL) ? r_k : r_j);
            w_ra_b = f_addr((r_op == OP_MUL) ? r_k : r_i, r_j);
        end else if (r_state == ST_IREAD) begin
            w_ra_a = f_addr(IDX_W'(r_k[1]), IDX_W'(r_k[0]));
        end
    end

    // Element arithmetic.
    assign w_sum  = r_acc + WIDE_W'(r_prod);
    assign w_sat  = f_sat32(r_wide);
    assign w_last = (DIM_W'(r_i) == r_nr - DIM_W'(1)) && (DIM_W'(r_j) == r_nc - DIM_W'(1));

    // Cofactor for the inverse element being worked on.
    always_comb begin
        unique case (r_k[1:0])
            2'd0:    w_num = 33'(r_m[3]);
            2'd1:    w_num = -33'(r_m[1]);
            2'd2:    w_num = -33'(r_m[2]);
            default: w_num = 33'(r_m[0]);
        endcase
        w_nmag = w_num[32] ? 32'(-w_num) : w_num[31:0];
    end

    // One restoring division step.
    assign w_rr = {r_rem, r_dvd[DIV_W-1]};
    assign w_ge = (w_rr >= {1'b0, r_dmag});

    // Floor, sign and saturation of the quotient.
    assign w_sing = (r_det == '0);
    always_comb begin
        w_imag = {1'b0, r_q} + 34'(r_neg && (r_rem != '0));
        w_iovf = r_big || (r_neg ? (w_imag > 34'h0_8000_0000) : (r_q > 33'h0_7FFF_FFFF));
        if (w_sing) begin
            w_ival = '0;
        end else if (w_iovf) begin
            w_ival = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            w_ival = r_neg ? -w_imag[31:0] : r_q[31:0];
        end
    end

    // Sequencer: next state and control.
    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        w_we_a     = 1'b0;
        w_we_b     = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    w_we_a  = (i_q_ent.kind == K_LOAD_A);
                    w_we_b  = (i_q_ent.kind == K_LOAD_B);
                    if (i_q_ent.kind == K_COMP) begin
                        n_state = (i_q_ent.op == OP_INV) ? ST_IREAD : ST_READ;
                    end
                end
            end
            ST_READ: n_state = ST_EXEC;
            ST_EXEC: begin
                n_state = (r_op == OP_ADD || r_op == OP_SUB) ? ST_EMIT : ST_ACC;
            end
            ST_ACC: begin
                n_state = (r_op == OP_MUL && DIM_W'(r_k) != r_nk - DIM_W'(1)) ?
                          ST_READ : ST_EMIT;
            end
            ST_EMIT: begin
                if (w_oslot) begin
                    w_load_out = 1'b1;
                    n_state = w_last ? ST_IDLE : ST_READ;
                end
            end
            ST_IREAD: n_state = ST_ICAP;
            ST_ICAP:  n_state = (r_k[1:0] == 2'd3) ? ST_DET0 : ST_IREAD;
            ST_DET0:  n_state = ST_DET1;
            ST_DET1:  n_state = ST_DET2;
            ST_DET2:  n_state = ST_IINIT;
            ST_IINIT: n_state = w_sing ? ST_IEMIT : ST_DIV;
            ST_DIV: begin
                if (r_cnt == DC_W'(1)) begin
                    n_state = ST_IEMIT;
                end
            end
            ST_IEMIT: begin
                if (w_oslot) begin
                    w_load_out = 1'b1;
                    n_state = (r_k[1:0] == 2'd3) ? ST_IDLE : ST_IINIT;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state: sequencer, valid bits, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_a_vld <= '0;
            r_b_vld <= '0;
            r_a_rv  <= 1'b0;
            r_b_rv  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_we_a) begin
                r_a_vld[w_waddr] <= 1'b1;
            end
            if (w_we_b) begin
                r_b_vld[w_waddr] <= 1'b1;
            end
            r_a_rv <= r_a_vld[w_ra_a];
            r_b_rv <= r_b_vld[w_ra_b];
            if (w_load_out) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && i_q_ent.kind == K_COMP) begin
                    r_op    <= i_q_ent.op;
                    r_scale <= i_q_ent.value;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_k     <= '0;
                    r_acc   <= '0;
                    r_nr    <= f_dim(i_num_rows);
                    r_nk    <= f_dim(i_inner_dim);
                    r_nc    <= (i_q_ent.op == OP_MUL) ? f_dim(i_num_cols) : f_dim(i_inner_dim);
                end
            end
            ST_EXEC: begin
                if (r_op == OP_ADD) begin
                    r_wide <= WIDE_W'(w_a) + WIDE_W'(w_b);
                end else if (r_op == OP_SUB) begin
                    r_wide <= WIDE_W'(w_a) - WIDE_W'(w_b);
                end else if (r_op == OP_MUL) begin
                    r_prod <= w_a * w_b;
                end else begin
                    r_prod <= w_a * r_scale;
                end
            end
            ST_ACC: begin
                if (r_op == OP_MUL && DIM_W'(r_k) != r_nk - DIM_W'(1)) begin
                    r_acc <= w_sum;
                    r_k   <= r_k + IDX_W'(1);
                end else begin
                    r_wide <= w_sum >>> FRAC_BITS;
                end
            end
            ST_EMIT: begin
                if (w_oslot) begin
                    r_acc <= '0;
                    r_k   <= '0;
                    if (DIM_W'(r_j) == r_nc - DIM_W'(1)) begin
                        r_j <= '0;
                        r_i <= r_i + IDX_W'(1);
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
            end
            ST_ICAP: begin
                r_m[r_k[1:0]] <= w_a;
                r_k <= (r_k[1:0] == 2'd3) ? '0 : r_k + IDX_W'(1);
            end
            ST_DET0: begin
                r_prod <= r_m[0] * r_m[3];
            end
            ST_DET1: begin
                r_acc  <= WIDE_W'(r_prod);
                r_prod <= r_m[1] * r_m[2];
            end
            ST_DET2: begin
                r_det <= w_sum[64:0] - 65'(r_prod) - 65'(r_prod);
            end
            ST_IINIT: begin
                r_neg  <= w_num[32] ^ r_det[64];
                r_dvd  <= DIV_W'(w_nmag) << (2 * FRAC_BITS);
                r_dmag <= r_det[64] ? 64'(-r_det) : r_det[63:0];
                r_rem  <= '0;
                r_q    <= '0;
                r_big  <= 1'b0;
                r_cnt  <= DC_W'(DIV_W);
            end
            ST_DIV: begin
                r_rem <= w_ge ? 64'(w_rr - {1'b0, r_dmag}) : w_rr[63:0];
                r_q   <= {r_q[31:0], w_ge};
                r_big <= r_big || r_q[32];
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - DC_W'(1);
            end
            ST_IEMIT: begin
                if (w_oslot) begin
                    r_k <= r_k + IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            if (r_state == ST_EMIT) begin
                o_out_row       <= r_i;
                o_out_col       <= r_j;
                o_out_value     <= $signed(w_sat[DATA_W-1:0]);
                o_last_elem     <= w_last;
                o_overflow_flag <= w_sat[DATA_W];
                o_singular_flag <= 1'b0;
            end else begin
                o_out_row       <= IDX_W'(r_k[1]);
                o_out_col       <= IDX_W'(r_k[0]);
                o_out_value     <= $signed(w_ival);
                o_last_elem     <= (r_k[1:0] == 2'd3);
                o_overflow_flag <= !w_sing && w_iovf;
                o_singular_flag <= w_sing;
            end
        end
    end

    assign o_out_valid = r_ovld;

endmodule

`default_nettype wire

[rtl/small_matrix_arithmetic_unit_core.sv]
// Top level of the small matrix arithmetic unit: configuration registers on
// an APB-style port, front end and execution side. Depends on smau_pkg,
// smau_front, smau_back and smau_ram.
//
// Usage: items arrive on the input channel (valid/ready). Loads of A or B
// write one element and give no result; a compute item streams its result
// matrix row by row on the output channel (valid/ready), the last element
// marked. A two-entry queue separates intake from execution, so loads are
// taken one per cycle while the execution side is free.
// Steps per item: a load is written as it leaves the queue. Add and subtract
// read, execute and emit each element, scale adds an accumulate step, and
// multiply reads, multiplies and accumulates once per term before it emits.
// The 2x2 inverse reads the four corner elements and forms the determinant,
// then runs the bit-serial restoring divider for each element.
// From acceptance, an item passes through the queue, the sequencer steps
// above and the result register before its first result appears.
// Reset clears both stores to zero (per-entry valid bits) and sets all three
// dimension registers to 2. When the receiver stalls, the result register
// holds its item and the sequencer waits; the queue keeps accepting until full.
`default_nettype none

module small_matrix_arithmetic_unit_core import smau_pkg::*; #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [3:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_req_type,
    input  wire logic [IDX_W-1:0]         i_elem_row,
    input  wire logic [IDX_W-1:0]         i_elem_col,
    input  wire logic signed [DATA_W-1:0] i_elem_value,
    input  wire logic [2:0]               i_op_code,
    input  wire logic signed [DATA_W-1:0] i_scale_factor,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [IDX_W-1:0]              o_out_row,
    output logic [IDX_W-1:0]              o_out_col,
    output logic signed [DATA_W-1:0]      o_out_value,
    output logic                          o_last_elem,
    output logic                          o_overflow_flag,
    output logic                          o_singular_flag
);

    logic [DIM_W-1:0] r_num_rows, r_inner_dim, r_num_cols;
    logic             w_wr;
    logic             w_q_valid;
    logic             w_q_pop;
    t_qent            w_q_ent;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Dimension registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= DIM_W'(2);
            r_inner_dim <= DIM_W'(2);
            r_num_cols  <= DIM_W'(2);
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_NUM_ROWS:  r_num_rows  <= pwdata[DIM_W-1:0];
                REG_INNER_DIM: r_inner_dim <= pwdata[DIM_W-1:0];
                REG_NUM_COLS:  r_num_cols  <= pwdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[3:2])
            REG_NUM_ROWS:  prdata = 32'(r_num_rows);
            REG_INNER_DIM: prdata = 32'(r_inner_dim);
            REG_NUM_COLS:  prdata = 32'(r_num_cols);
            default:       prdata = '0;
        endcase
    end

    smau_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_elem_row     (i_elem_row),
        .i_elem_col     (i_elem_col),
        .i_elem_value   (i_elem_value),
        .i_op_code      (i_op_code),
        .i_scale_factor (i_scale_factor),
        .o_q_valid      (w_q_valid),
        .o_q_ent        (w_q_ent),
        .i_q_pop        (w_q_pop)
    );

    smau_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_ent         (w_q_ent),
        .o_q_pop         (w_q_pop),
        .i_num_rows      (r_num_rows),
        .i_inner_dim     (r_inner_dim),
        .i_num_cols      (r_num_cols),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_out_value     (o_out_value),
        .o_last_elem     (o_last_elem),
        .o_overflow_flag (o_overflow_flag),
        .o_singular_flag (o_singular_flag)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for small_matrix_arithmetic_unit_core: element loads,
// the five matrix operations and dimension settings, checked against a predictor.
// Depends on smau_pkg and the RTL of the block; needs no files or arguments.
`default_nettype none

module tb;
    import smau_pkg::*;

    localparam int  CLK_HALF   = 5;
    localparam int  CYCLE_CAP  = 2000000;
    localparam int  DRAIN_WAIT = 300;
    localparam int  FRAC       = 16;
    localparam int  RAND_ITEMS = 210;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        last;
        logic        ovf;
        logic        sing;
    } elem_result_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_req_type;
    logic [2:0]  i_elem_row, i_elem_col, i_op_code;
    logic signed [31:0] i_elem_value, i_scale_factor;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_out_row, o_out_col;
    logic signed [31:0] o_out_value;
    logic        o_last_elem, o_overflow_flag, o_singular_flag;

    // Predictor state: both stores and the three dimension registers.
    logic [31:0]  store_a [64];
    logic [31:0]  store_b [64];
    logic [3:0]   reg_rows, reg_inner, reg_cols;
    elem_result_t pending_results [$];

    int  errors;
    int  cycles;
    int  items_sent;
    int  results_seen;
    int  computes_sent;
    bit  quiet;
    int  out_stall;

    small_matrix_arithmetic_unit_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_elem_row(i_elem_row), .i_elem_col(i_elem_col),
        .i_elem_value(i_elem_value), .i_op_code(i_op_code),
        .i_scale_factor(i_scale_factor),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_row(o_out_row), .o_out_col(o_out_col), .o_out_value(o_out_value),
        .o_last_elem(o_last_elem), .o_overflow_flag(o_overflow_flag),
        .o_singular_flag(o_singular_flag)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Cycle counter with a hard limit on the run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Gap length: mostly none or short, occasionally long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Element values: extremes, small fixed-point numbers and raw random words.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom_range(0, 8) << FRAC;
            4: return -($urandom_range(0, 8) << FRAC) + $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // Dimension register value, clamped as the block does.
    function automatic int dim_used(logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > 4'd8) return 8;
        return int'(v);
    endfunction

    // Saturate to 32 bits; bit 32 of the return is the overflow flag.
    function automatic logic [32:0] saturate(logic signed [129:0] v);
        logic signed [129:0] hi, lo;
        hi = 130'sd2147483647;
        lo = -130'sd2147483648;
        if (v > hi) return {1'b1, 32'h7FFF_FFFF};
        if (v < lo) return {1'b1, 32'h8000_0000};
        return {1'b0, v[31:0]};
    endfunction

    // floor(num * 2^32 / det), saturated; det is nonzero.
    function automatic logic [32:0] inverse_elem(logic signed [129:0] num,
                                                  logic signed [129:0] det);
        logic [129:0]        mag, div, quo, rem;
        logic signed [129:0] res;
        logic                neg;
        neg = (num < 0) != (det < 0);
        mag = (num < 0 ? -num : num) << (2 * FRAC);
        div = det < 0 ? -det : det;
        quo = mag / div;
        rem = mag % div;
        res = neg ? -$signed(quo) - (rem != 0) : $signed(quo);
        return saturate(res);
    endfunction

    function automatic void push_result(int r, int c, logic [32:0] sv,
                                        logic last, logic sing);
        elem_result_t e;
        e.row = 3'(r); e.col = 3'(c); e.value = sv[31:0];
        e.last = last; e.ovf = sv[32]; e.sing = sing;
        pending_results.push_back(e);
    endfunction

    // Works out the results of one accepted item and updates the stores.
    function automatic void predict_item(logic [1:0] req, logic [2:0] row,
            logic [2:0] col, logic [31:0] val, logic [2:0] op, logic [31:0] scal);
        int nr, nk, nc, ncols;
        logic signed [129:0] a, b, acc, det;
        logic signed [129:0] nums [4];
        if (req == REQ_LOAD_A) begin
            store_a[row * 8 + col] = val;
            return;
        end
        if (req == REQ_LOAD_B) begin
            store_b[row * 8 + col] = val;
            return;
        end
        if (req != REQ_COMP || op > OP_INV) return;
        computes_sent++;
        if (op == OP_INV) begin
            det = $signed(store_a[0]) * $signed(store_a[9])
                - $signed(store_a[1]) * $signed(store_a[8]);
            nums[0] = $signed(store_a[9]);
            nums[1] = -$signed(store_a[1]);
            nums[2] = -$signed(store_a[8]);
            nums[3] = $signed(store_a[0]);
            for (int k = 0; k < 4; k++) begin
                if (det == 0) push_result(k >> 1, k & 1, 33'd0, k == 3, 1'b1);
                else push_result(k >> 1, k & 1, inverse_elem(nums[k], det), k == 3, 1'b0);
            end
            return;
        end
        nr = dim_used(reg_rows);
        nk = dim_used(reg_inner);
        nc = dim_used(reg_cols);
        ncols = (op == OP_MUL) ? nc : nk;
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < ncols; j++) begin
                a = $signed(store_a[i * 8 + j]);
                b = $signed(store_b[i * 8 + j]);
                case (op)
                    OP_ADD:   acc = a + b;
                    OP_SUB:   acc = a - b;
                    OP_SCALE: acc = (a * $signed(scal)) >>> FRAC;
                    default: begin
                        acc = 0;
                        for (int k = 0; k < nk; k++)
                            acc = acc + $signed(store_a[i * 8 + k]) * $signed(store_b[k * 8 + j]);
                        acc = acc >>> FRAC;
                    end
                endcase
                push_result(i, j, saturate(acc), i == nr - 1 && j == ncols - 1, 1'b0);
            end
        end
    endfunction

    // Sends one item and predicts its results once it is accepted.
    task automatic send_item(logic [1:0] req, logic [2:0] row, logic [2:0] col,
                             logic [31:0] val, logic [2:0] op, logic [31:0] scal);
        int gap;
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_req_type     = req;
        i_elem_row     = row;
        i_elem_col     = col;
        i_elem_value   = val;
        i_op_code      = op;
        i_scale_factor = scal;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(req, row, col, val, op, scal);
        items_sent++;
        gap = gap_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic load_elem(logic [1:0] req, int row, int col, logic [31:0] val);
        send_item(req, 3'(row), 3'(col), val, 3'($urandom), $urandom);
    endtask

    task automatic compute(logic [2:0] op, logic [31:0] scal);
        send_item(REQ_COMP, 3'($urandom), 3'($urandom), $urandom, op, scal);
    endtask

    // Waits until every expected result has arrived and the block has settled.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // One register write: setup phase, then access phase.
    task automatic write_reg(logic [1:0] index, logic [3:0] value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {index, 2'b00};
        pwdata = {28'd0, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (index)
            REG_NUM_ROWS:  reg_rows  = value;
            REG_INNER_DIM: reg_inner = value;
            default:       reg_cols  = value;
        endcase
    endtask

    task automatic set_dims(logic [3:0] rows, logic [3:0] inner, logic [3:0] cols);
        wait_idle();
        write_reg(REG_NUM_ROWS, rows);
        write_reg(REG_INNER_DIM, inner);
        write_reg(REG_NUM_COLS, cols);
    endtask

    // Dimension value: mostly small, sometimes large, rarely out of range.
    function automatic logic [3:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 4'($urandom_range(1, 3));
        if (r < 90) return 4'($urandom_range(4, 8));
        return ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
    endfunction

    // Result receiver: stalls of random length with quiet stretches.
    initial begin
        i_out_ready = 1'b0;
        out_stall = 0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                i_out_ready = 1'b1;
            end else if (out_stall > 0) begin
                i_out_ready = 1'b0;
                out_stall--;
            end else begin
                i_out_ready = 1'b1;
                if ($urandom_range(0, 3) == 0) out_stall = gap_len();
            end
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        elem_result_t e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result row %0d col %0d value %h",
                         $time, o_out_row, o_out_col, o_out_value);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_out_row !== e.row || o_out_col !== e.col || o_out_value !== e.value
                        || o_last_elem !== e.last || o_overflow_flag !== e.ovf
                        || o_singular_flag !== e.sing) begin
                    $display("%0t: mismatch expected r%0d c%0d v=%h last=%b ovf=%b sing=%b",
                             $time, e.row, e.col, e.value, e.last, e.ovf, e.sing);
                    $display("%0t:          actual   r%0d c%0d v=%h last=%b ovf=%b sing=%b",
                             $time, o_out_row, o_out_col, o_out_value, o_last_elem,
                             o_overflow_flag, o_singular_flag);
                    errors++;
                end
            end
        end
    end

    // Directed cases: extremes, every operation, singular and ignored items.
    task automatic test_directed();
        quiet = 1'b1;
        compute(OP_INV, 32'd0);
        load_elem(REQ_LOAD_A, 0, 0, 32'h7FFF_FFFF);
        load_elem(REQ_LOAD_A, 0, 1, 32'h8000_0000);
        load_elem(REQ_LOAD_A, 1, 0, 32'h0001_0000);
        load_elem(REQ_LOAD_A, 1, 1, 32'h0002_0000);
        load_elem(REQ_LOAD_B, 0, 0, 32'h7FFF_FFFF);
        load_elem(REQ_LOAD_B, 0, 1, 32'h8000_0000);
        load_elem(REQ_LOAD_B, 1, 0, 32'hFFFF_FFFF);
        load_elem(REQ_LOAD_B, 1, 1, 32'h0003_0000);
        load_elem(REQ_LOAD_A, 7, 7, 32'h8000_0000);
        load_elem(REQ_LOAD_B, 7, 7, 32'h7FFF_FFFF);
        quiet = 1'b0;
        compute(OP_ADD, 32'd0);
        compute(OP_SUB, 32'd0);
        compute(OP_MUL, 32'd0);
        compute(OP_SCALE, 32'h8000_0000);
        compute(OP_SCALE, 32'h7FFF_FFFF);
        compute(OP_INV, 32'd0);
        send_item(2'd3, 3'd7, 3'd7, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
        compute(3'd5, 32'd0);
        compute(3'd6, 32'd0);
        // A singular corner: second row is twice the first.
        load_elem(REQ_LOAD_A, 0, 0, 32'h0001_0000);
        load_elem(REQ_LOAD_A, 0, 1, 32'h0002_0000);
        load_elem(REQ_LOAD_A, 1, 0, 32'h0002_0000);
        load_elem(REQ_LOAD_A, 1, 1, 32'h0004_0000);
        compute(OP_INV, 32'd0);
    endtask

    // Largest and out-of-range dimension settings, with loads in every row and column.
    task automatic test_dim_extremes();
        for (int r = 0; r < 8; r++) begin
            load_elem(REQ_LOAD_A, r, 7 - r, pick_value());
            load_elem(REQ_LOAD_B, 7 - r, r, pick_value());
        end
        set_dims(4'd15, 4'd15, 4'd15);
        compute(OP_MUL, 32'd0);
        compute(OP_ADD, 32'd0);
        set_dims(4'd0, 4'd0, 4'd0);
        compute(OP_MUL, 32'd0);
        compute(OP_SCALE, $urandom);
        set_dims(4'd8, 4'd1, 4'd8);
        compute(OP_MUL, 32'd0);
        set_dims(4'd1, 4'd8, 4'd1);
        compute(OP_SUB, 32'd0);
    endtask

    // Random rounds: new dimensions now and then, loads, then a compute or an ignored item.
    task automatic test_random();
        int rows, cols, loads;
        int start;
        start = items_sent;
        while (items_sent - start < RAND_ITEMS) begin
            quiet = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 4) == 0) set_dims(pick_dim(), pick_dim(), pick_dim());
            rows = dim_used(reg_rows);
            cols = dim_used(reg_inner) > dim_used(reg_cols) ?
                   dim_used(reg_inner) : dim_used(reg_cols);
            loads = $urandom_range(0, 8);
            for (int n = 0; n < loads; n++) begin
                if ($urandom_range(0, 9) == 0)
                    load_elem(2'($urandom_range(0, 1)), $urandom_range(0, 7),
                              $urandom_range(0, 7), $urandom);
                else
                    load_elem(2'($urandom_range(0, 1)), $urandom_range(0, rows - 1),
                              $urandom_range(0, cols - 1), pick_value());
            end
            if ($urandom_range(0, 19) == 0)
                send_item(2'd3, 3'($urandom), 3'($urandom), $urandom, 3'($urandom),
                          $urandom);
            else if ($urandom_range(0, 19) == 0)
                compute(3'($urandom_range(5, 7)), $urandom);
            else
                compute(3'($urandom_range(0, 4)), pick_value());
        end
        quiet = 1'b0;
    endtask

    // Stimulus sequence.
    initial begin
        errors = 0; cycles = 0; items_sent = 0; results_seen = 0; computes_sent = 0;
        quiet = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_in_valid = 1'b0; i_req_type = '0; i_elem_row = '0; i_elem_col = '0;
        i_elem_value = '0; i_op_code = '0; i_scale_factor = '0;
        for (int k = 0; k < 64; k++) begin
            store_a[k] = '0;
            store_b[k] = '0;
        end
        reg_rows = 4'd2; reg_inner = 4'd2; reg_cols = 4'd2;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_dim_extremes();
        test_random();
        wait_idle();

        $display("Covered %0d items, %0d compute commands and %0d result items,",
                 items_sent, computes_sent, results_seen);
        $display("over loads, all five operations and a range of dimension settings.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
